FILE: hdl/vcbp_pkg.sv
package vcbp_pkg;

	localparam int CFG_AW = 4;

	localparam logic [1:0] REG_SMALL  = 2'd0;
	localparam logic [1:0] REG_MEDIUM = 2'd1;
	localparam logic [1:0] REG_LARGE  = 2'd2;

	typedef enum logic [1:0] {
		FUNC_LOAD_BIN  = 2'd0,
		FUNC_LOAD_ITEM = 2'd1,
		FUNC_RUN       = 2'd2
	} func_t;

	typedef struct packed {
		logic [15:0] large_volume;
		logic [15:0] medium_volume;
		logic [15:0] small_volume;
	} cfg_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] item_weight;
		logic [15:0] bin_cost;
		logic [15:0] bin_room;
		logic [15:0] bin_volume;
	} req_t;

	typedef struct packed {
		logic [15:0] volume;
		logic [15:0] room;
		logic [15:0] cost;
	} bin_t;

	typedef struct packed {
		logic [15:0]        volume;
		logic signed [23:0] room;
		logic [15:0]        cost;
	} booked_t;

	typedef struct packed {
		logic        used;
		logic [15:0] volume;
		logic [15:0] cost;
	} spare_t;

	typedef struct packed {
		logic       out_of_bins;
		logic [6:0] large_count;
		logic [6:0] medium_count;
		logic [6:0] small_count;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_BOOK_RD,
		S_BOOK,
		S_ITEM_RD,
		S_ITEM,
		S_SUB,
		S_INS_RD,
		S_INS,
		S_INS_PUT,
		S_SP_START,
		S_SP_RD,
		S_SP_GET,
		S_SP_IRD,
		S_SP_INS,
		S_SP_PUT,
		S_SW_START,
		S_SW_RD,
		S_SW_GET,
		S_SJ_RD,
		S_SJ,
		S_SW_NEXT,
		S_DONE
	} state_t;

endpackage

FILE: hdl/variable_cost_bin_packing_unit.sv
// Channel   Role    Handshake                 Contents
// s_*       in      s_tvalid / s_tready       func on tuser, bin and item fields on tdata
// m_*       out     m_tvalid / m_tready       class counts and out_of_bins, one per run
// p*        config  psel, penable, pwrite     class volumes at byte addresses 0, 4, 8
//
// Load words are taken while the unit is idle. A run walks the stores in one synchronous
// RAM each: it reads the items one by one with a sorted reinsertion into the booked list
// for each, then builds the cost-ordered spare list and runs the swap search. Reset clears
// the bin and item counts and control; the RAMs hold no reset and need no clearing pass.
// A finished report sits in the output register while loads are still taken.
module variable_cost_bin_packing_unit #(
	parameter int MAX_BINS  = 64,
	parameter int MAX_ITEMS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,  // bin_volume, bin_room, bin_cost, item_weight
	input  logic [1:0]                  s_tuser,  // func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata,  // small_count, medium_count, large_count,
	                                              // out_of_bins
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vcbp_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	vcbp_pkg::req_t req;
	vcbp_pkg::cfg_t cfg;
	vcbp_pkg::res_t res, res_q;
	logic           res_valid, res_ready, m_tvalid_q;

	assign req.func        = vcbp_pkg::func_t'(s_tuser);
	assign req.bin_volume  = s_tdata[15:0];
	assign req.bin_room    = s_tdata[31:16];
	assign req.bin_cost    = s_tdata[47:32];
	assign req.item_weight = s_tdata[63:48];

	assign res_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {2'b00, res_q};

	vcbp_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.reg_sel(paddr[3:2]), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	vcbp_seq #(.MAX_BINS(MAX_BINS), .MAX_ITEMS(MAX_ITEMS)) u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready), .req(req),
		.cfg(cfg), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

FILE: hdl/vcbp_ram.sv
module vcbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/vcbp_cfg.sv
module vcbp_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          reg_sel,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output vcbp_pkg::cfg_t      cfg
);

	vcbp_pkg::cfg_t cfg_q;
	logic           wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (reg_sel)
				vcbp_pkg::REG_SMALL:  cfg_q.small_volume  <= pwdata[15:0];
				vcbp_pkg::REG_MEDIUM: cfg_q.medium_volume <= pwdata[15:0];
				vcbp_pkg::REG_LARGE:  cfg_q.large_volume  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			vcbp_pkg::REG_SMALL:  prdata = {16'd0, cfg_q.small_volume};
			vcbp_pkg::REG_MEDIUM: prdata = {16'd0, cfg_q.medium_volume};
			vcbp_pkg::REG_LARGE:  prdata = {16'd0, cfg_q.large_volume};
			default:              prdata = '0;
		endcase
	end

endmodule

FILE: hdl/vcbp_seq.sv
module vcbp_seq #(
	parameter int MAX_BINS  = 64,
	parameter int MAX_ITEMS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vcbp_pkg::req_t  req,
	input  vcbp_pkg::cfg_t  cfg,
	output logic            res_valid,
	input  logic            res_ready,
	output vcbp_pkg::res_t  res
);

	localparam int BCW = $clog2(MAX_BINS + 1);
	localparam int BIW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int ICW = $clog2(MAX_ITEMS + 1);
	localparam int IIW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW  = BCW + 1;

	vcbp_pkg::state_t state_q, state_d;

	logic [BCW-1:0] bin_count_q, avail_q, bcnt_q, k_q, sb_q, sj_q, bi_q;
	logic [ICW-1:0] item_count_q, it_q;
	logic           first_q, err_q;
	logic [15:0]    w_q;
	logic [CW-1:0]  cnt_s_q, cnt_m_q, cnt_l_q;
	vcbp_pkg::booked_t top_q, cur_q, be_q;
	vcbp_pkg::spare_t  nb_q;

	logic              bin_we;
	logic [BIW-1:0]    bin_raddr;
	vcbp_pkg::bin_t    bin_wdata, bin_rdata;
	logic              item_we;
	logic [15:0]       item_rdata;
	logic              bk_we;
	logic [BIW-1:0]    bk_waddr, bk_raddr;
	vcbp_pkg::booked_t bk_wdata, bk_rdata;
	logic              sp_we;
	logic [BIW-1:0]    sp_waddr, sp_raddr;
	vcbp_pkg::spare_t  sp_wdata, sp_rdata;

	logic              accept;
	logic [BCW-1:0]    k_m1;
	logic [ICW-1:0]    it_m1;
	vcbp_pkg::booked_t book_new;
	logic              fits, bk_shift, sp_shift, hit;
	logic signed [24:0] sub_d;
	logic signed [23:0] sub_room;
	logic signed [25:0] used_amt;
	vcbp_pkg::state_t   item_next;

	function automatic logic [6:0] clamp(input logic [CW-1:0] c);
		clamp = (32'(c) > 32'd127) ? 7'd127 : 7'(c);
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == vcbp_pkg::S_IDLE);
	assign k_m1     = k_q - BCW'(1);
	assign it_m1    = it_q - ICW'(1);

	assign book_new.volume = bin_rdata.volume;
	assign book_new.room   = $signed({8'd0, bin_rdata.room});
	assign book_new.cost   = bin_rdata.cost;

	assign fits     = $signed({9'd0, item_rdata}) <= $signed({top_q.room[23], top_q.room});
	assign sub_d    = $signed({top_q.room[23], top_q.room}) - $signed({9'd0, w_q});
	assign sub_room = (sub_d[24:23] == 2'b10) ? 24'sh800000 : sub_d[23:0];
	assign bk_shift = bk_rdata.room > cur_q.room;
	assign sp_shift = sp_rdata.cost > nb_q.cost;
	assign used_amt = $signed({10'd0, be_q.volume}) - $signed({{2{be_q.room[23]}}, be_q.room});
	assign hit      = !sp_rdata.used && (used_amt < $signed({10'd0, sp_rdata.volume}))
		&& (be_q.cost > sp_rdata.cost);
	assign item_next = (it_q == '0) ? vcbp_pkg::S_SP_START : vcbp_pkg::S_ITEM_RD;

	assign bin_we    = accept && (req.func == vcbp_pkg::FUNC_LOAD_BIN)
		&& (bin_count_q < BCW'(MAX_BINS));
	assign bin_wdata = '{volume: req.bin_volume, room: req.bin_room, cost: req.bin_cost};
	assign bin_raddr = (state_q == vcbp_pkg::S_SP_RD) ? sb_q[BIW-1:0] : avail_q[BIW-1:0];
	assign item_we   = accept && (req.func == vcbp_pkg::FUNC_LOAD_ITEM)
		&& (item_count_q < ICW'(MAX_ITEMS));
	assign bk_raddr  = (state_q == vcbp_pkg::S_SW_RD) ? bi_q[BIW-1:0] : k_m1[BIW-1:0];
	assign sp_raddr  = (state_q == vcbp_pkg::S_SJ_RD) ? sj_q[BIW-1:0] : k_m1[BIW-1:0];

	always_comb begin
		bk_we    = 1'b0;
		bk_waddr = k_q[BIW-1:0];
		bk_wdata = cur_q;
		sp_we    = 1'b0;
		sp_waddr = k_q[BIW-1:0];
		sp_wdata = nb_q;
		case (state_q)
			vcbp_pkg::S_BOOK: begin
				bk_we    = 1'b1;
				bk_waddr = bcnt_q[BIW-1:0];
				bk_wdata = book_new;
			end
			vcbp_pkg::S_INS: begin
				bk_we = 1'b1;
				if (bk_shift) begin
					bk_wdata = bk_rdata;
				end
			end
			vcbp_pkg::S_INS_PUT: bk_we = 1'b1;
			vcbp_pkg::S_SP_INS: begin
				if (sp_shift) begin
					sp_we    = 1'b1;
					sp_wdata = sp_rdata;
				end
			end
			vcbp_pkg::S_SP_PUT: sp_we = 1'b1;
			vcbp_pkg::S_SJ: begin
				if (hit) begin
					sp_we         = 1'b1;
					sp_waddr      = sj_q[BIW-1:0];
					sp_wdata      = sp_rdata;
					sp_wdata.used = 1'b1;
				end
			end
			default: ;
		endcase
	end

	vcbp_ram #(.WIDTH($bits(vcbp_pkg::bin_t)), .DEPTH(MAX_BINS)) u_bin_ram (
		.clk(clk), .we(bin_we), .waddr(bin_count_q[BIW-1:0]), .wdata(bin_wdata),
		.raddr(bin_raddr), .rdata(bin_rdata)
	);

	vcbp_ram #(.WIDTH(16), .DEPTH(MAX_ITEMS)) u_item_ram (
		.clk(clk), .we(item_we), .waddr(item_count_q[IIW-1:0]), .wdata(req.item_weight),
		.raddr(it_m1[IIW-1:0]), .rdata(item_rdata)
	);

	vcbp_ram #(.WIDTH($bits(vcbp_pkg::booked_t)), .DEPTH(MAX_BINS)) u_booked_ram (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.raddr(bk_raddr), .rdata(bk_rdata)
	);

	vcbp_ram #(.WIDTH($bits(vcbp_pkg::spare_t)), .DEPTH(MAX_BINS)) u_spare_ram (
		.clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
		.raddr(sp_raddr), .rdata(sp_rdata)
	);

	always_comb begin
		state_d   = state_q;
		res_valid = (state_q == vcbp_pkg::S_DONE);
		res.small_count  = clamp(cnt_s_q);
		res.medium_count = clamp(cnt_m_q);
		res.large_count  = clamp(cnt_l_q);
		res.out_of_bins  = err_q;
		case (state_q)
			vcbp_pkg::S_IDLE: begin
				if (accept && (req.func == vcbp_pkg::FUNC_RUN)) begin
					state_d = (bin_count_q == '0) ? vcbp_pkg::S_SP_START : vcbp_pkg::S_BOOK_RD;
				end
			end
			vcbp_pkg::S_BOOK_RD: state_d = vcbp_pkg::S_BOOK;
			vcbp_pkg::S_BOOK:    state_d = first_q ? item_next : vcbp_pkg::S_SUB;
			vcbp_pkg::S_ITEM_RD: state_d = vcbp_pkg::S_ITEM;
			vcbp_pkg::S_ITEM: begin
				if (fits) begin
					state_d = vcbp_pkg::S_SUB;
				end else if (avail_q == '0) begin
					state_d = vcbp_pkg::S_SP_START;
				end else begin
					state_d = vcbp_pkg::S_BOOK_RD;
				end
			end
			vcbp_pkg::S_SUB: begin
				state_d = (bcnt_q == BCW'(1)) ? vcbp_pkg::S_INS_PUT : vcbp_pkg::S_INS_RD;
			end
			vcbp_pkg::S_INS_RD: state_d = vcbp_pkg::S_INS;
			vcbp_pkg::S_INS: begin
				if (!bk_shift) begin
					state_d = item_next;
				end else begin
					state_d = (k_q == BCW'(1)) ? vcbp_pkg::S_INS_PUT : vcbp_pkg::S_INS_RD;
				end
			end
			vcbp_pkg::S_INS_PUT: state_d = item_next;
			vcbp_pkg::S_SP_START: begin
				state_d = (avail_q == '0) ? vcbp_pkg::S_SW_START : vcbp_pkg::S_SP_RD;
			end
			vcbp_pkg::S_SP_RD: state_d = vcbp_pkg::S_SP_GET;
			vcbp_pkg::S_SP_GET: begin
				state_d = (sb_q == '0) ? vcbp_pkg::S_SP_PUT : vcbp_pkg::S_SP_IRD;
			end
			vcbp_pkg::S_SP_IRD: state_d = vcbp_pkg::S_SP_INS;
			vcbp_pkg::S_SP_INS: begin
				if (sp_shift && (k_q != BCW'(1))) begin
					state_d = vcbp_pkg::S_SP_IRD;
				end else begin
					state_d = vcbp_pkg::S_SP_PUT;
				end
			end
			vcbp_pkg::S_SP_PUT: begin
				state_d = ((sb_q + BCW'(1)) == avail_q) ? vcbp_pkg::S_SW_START
					: vcbp_pkg::S_SP_RD;
			end
			vcbp_pkg::S_SW_START: begin
				state_d = (bcnt_q == '0) ? vcbp_pkg::S_DONE : vcbp_pkg::S_SW_RD;
			end
			vcbp_pkg::S_SW_RD: state_d = vcbp_pkg::S_SW_GET;
			vcbp_pkg::S_SW_GET: begin
				state_d = (avail_q == '0) ? vcbp_pkg::S_SW_NEXT : vcbp_pkg::S_SJ_RD;
			end
			vcbp_pkg::S_SJ_RD: state_d = vcbp_pkg::S_SJ;
			vcbp_pkg::S_SJ: begin
				if (hit || ((sj_q + BCW'(1)) == avail_q)) begin
					state_d = vcbp_pkg::S_SW_NEXT;
				end else begin
					state_d = vcbp_pkg::S_SJ_RD;
				end
			end
			vcbp_pkg::S_SW_NEXT: begin
				state_d = ((bi_q + BCW'(1)) == bcnt_q) ? vcbp_pkg::S_DONE : vcbp_pkg::S_SW_RD;
			end
			vcbp_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = vcbp_pkg::S_IDLE;
				end
			end
			default: state_d = vcbp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vcbp_pkg::S_IDLE;
			bin_count_q  <= '0;
			item_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (bin_we) begin
				bin_count_q <= bin_count_q + BCW'(1);
			end
			if (item_we) begin
				item_count_q <= item_count_q + ICW'(1);
			end
			if ((state_q == vcbp_pkg::S_DONE) && res_ready) begin
				bin_count_q  <= '0;
				item_count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vcbp_pkg::S_IDLE: begin
				if (accept && (req.func == vcbp_pkg::FUNC_RUN)) begin
					cnt_s_q <= '0;
					cnt_m_q <= '0;
					cnt_l_q <= '0;
					bcnt_q  <= '0;
					first_q <= 1'b1;
					it_q    <= item_count_q;
					err_q   <= (bin_count_q == '0);
					avail_q <= (bin_count_q == '0) ? '0 : bin_count_q - BCW'(1);
				end
			end
			vcbp_pkg::S_BOOK: begin
				top_q  <= book_new;
				bcnt_q <= bcnt_q + BCW'(1);
				if (book_new.cost != '0) begin
					cnt_s_q <= cnt_s_q + CW'(book_new.volume == cfg.small_volume);
					cnt_m_q <= cnt_m_q + CW'(book_new.volume == cfg.medium_volume);
					cnt_l_q <= cnt_l_q + CW'(book_new.volume == cfg.large_volume);
				end
			end
			vcbp_pkg::S_ITEM_RD: it_q <= it_m1;
			vcbp_pkg::S_ITEM: begin
				w_q <= item_rdata;
				if (!fits) begin
					first_q <= 1'b0;
					if (avail_q == '0) begin
						err_q <= 1'b1;
					end else begin
						avail_q <= avail_q - BCW'(1);
					end
				end
			end
			vcbp_pkg::S_SUB: begin
				cur_q      <= '{volume: top_q.volume, room: sub_room, cost: top_q.cost};
				top_q.room <= sub_room;
				k_q        <= bcnt_q - BCW'(1);
			end
			vcbp_pkg::S_INS: begin
				if (bk_shift) begin
					k_q <= k_m1;
					if (k_q == (bcnt_q - BCW'(1))) begin
						top_q <= bk_rdata;
					end
				end
			end
			vcbp_pkg::S_SP_START: sb_q <= '0;
			vcbp_pkg::S_SP_GET: begin
				nb_q <= '{used: 1'b0, volume: bin_rdata.volume, cost: bin_rdata.cost};
				k_q  <= sb_q;
			end
			vcbp_pkg::S_SP_INS: begin
				if (sp_shift) begin
					k_q <= k_m1;
				end
			end
			vcbp_pkg::S_SP_PUT:   sb_q <= sb_q + BCW'(1);
			vcbp_pkg::S_SW_START: bi_q <= '0;
			vcbp_pkg::S_SW_GET: begin
				be_q <= bk_rdata;
				sj_q <= '0;
			end
			vcbp_pkg::S_SJ: begin
				if (hit) begin
					cnt_s_q <= cnt_s_q + CW'(sp_rdata.volume == cfg.small_volume)
						- CW'(be_q.volume == cfg.small_volume);
					cnt_m_q <= cnt_m_q + CW'(sp_rdata.volume == cfg.medium_volume)
						- CW'(be_q.volume == cfg.medium_volume);
					cnt_l_q <= cnt_l_q + CW'(sp_rdata.volume == cfg.large_volume)
						- CW'(be_q.volume == cfg.large_volume);
				end else begin
					sj_q <= sj_q + BCW'(1);
				end
			end
			vcbp_pkg::S_SW_NEXT: bi_q <= bi_q + BCW'(1);
			default: ;
		endcase
	end

endmodule

FILE: verif/testbench.sv
module testbench;

	typedef struct packed {
		logic [1:0]  f;
		logic [63:0] d;
	} word_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [vcbp_pkg::CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	word_t pend_words[$];
	vcbp_pkg::res_t report_q[$];
	int fails;
	int reports_seen;
	int runs_sent;
	int full_runs;
	bit no_gaps;

	// packer state mirror
	int cfg_sv, cfg_mv, cfg_lv;
	int bvol[64], broom[64], bcost[64];
	int nbins;
	int wgt[256];
	int nitems;
	int kv[64], kr[64], kc[64];
	int nk;
	int csm, cmd, clg;

	variable_cost_bin_packing_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	function automatic void class_bump(int vol, int d);
		if (vol == cfg_sv) csm += d;
		if (vol == cfg_mv) cmd += d;
		if (vol == cfg_lv) clg += d;
	endfunction

	function automatic logic [6:0] clamp7(int c);
		if (c < 0) return 7'd0;
		if (c > 127) return 7'd127;
		return c[6:0];
	endfunction

	function automatic void book_bin(int idx);
		kv[nk] = bvol[idx];
		kr[nk] = broom[idx];
		kc[nk] = bcost[idx];
		if (kc[nk] != 0) class_bump(kv[nk], 1);
		nk++;
	endfunction

	function automatic vcbp_pkg::res_t pack_bins();
		int sv[64], sc[64];
		bit su[64];
		int avail, i, j, k, w, t, used;
		bit err;
		vcbp_pkg::res_t r;
		csm = 0; cmd = 0; clg = 0; nk = 0; err = 0;
		avail = nbins;
		if (avail == 0) begin
			err = 1;
		end else begin
			avail--;
			book_bin(avail);
			for (i = nitems; i > 0; i--) begin
				w = wgt[i-1];
				if (!(w <= kr[nk-1])) begin
					if (avail == 0) begin
						err = 1;
						break;
					end
					avail--;
					book_bin(avail);
				end
				kr[nk-1] = kr[nk-1] - w;
				if (kr[nk-1] < -8388608) kr[nk-1] = -8388608;
				k = nk - 1;
				while (k > 0 && kr[k-1] > kr[k]) begin
					t = kv[k-1]; kv[k-1] = kv[k]; kv[k] = t;
					t = kr[k-1]; kr[k-1] = kr[k]; kr[k] = t;
					t = kc[k-1]; kc[k-1] = kc[k]; kc[k] = t;
					k--;
				end
			end
		end
		for (i = 0; i < avail; i++) begin
			k = i;
			while (k > 0 && sc[k-1] > bcost[i]) begin
				sv[k] = sv[k-1];
				sc[k] = sc[k-1];
				k--;
			end
			sv[k] = bvol[i];
			sc[k] = bcost[i];
			su[i] = 0;
		end
		for (i = 0; i < nk; i++) begin
			used = kv[i] - kr[i];
			for (j = 0; j < avail; j++) begin
				if (su[j]) continue;
				if (used < sv[j] && kc[i] > sc[j]) begin
					class_bump(kv[i], -1);
					class_bump(sv[j], 1);
					su[j] = 1;
					break;
				end
			end
		end
		nbins = 0;
		nitems = 0;
		r.small_count = clamp7(csm);
		r.medium_count = clamp7(cmd);
		r.large_count = clamp7(clg);
		r.out_of_bins = err;
		return r;
	endfunction

	function automatic void take_word(word_t x);
		case (x.f)
			vcbp_pkg::FUNC_LOAD_BIN: begin
				if (nbins < 64) begin
					bvol[nbins] = x.d[15:0];
					broom[nbins] = x.d[31:16];
					bcost[nbins] = x.d[47:32];
					nbins++;
				end
			end
			vcbp_pkg::FUNC_LOAD_ITEM: begin
				if (nitems < 256) begin
					wgt[nitems] = x.d[63:48];
					nitems++;
				end
			end
			vcbp_pkg::FUNC_RUN: begin
				if (nbins >= 64 || nitems >= 256) full_runs++;
				report_q = {report_q, pack_bins()};
			end
			default: ;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// input side
	int gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			gap = 0;
		end else begin
			if (s_tvalid && s_tready) take_word('{f: s_tuser, d: s_tdata});
			if (!(s_tvalid && !s_tready)) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 0;
				end else if (pend_words.size() > 0) begin
					word_t x;
					x = pend_words.pop_front();
					s_tuser <= x.f;
					s_tdata <= x.d;
					s_tvalid <= 1;
					gap = no_gaps ? 0 : $urandom_range(0, 12);
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// output side
	int stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				vcbp_pkg::res_t got, exp_r;
				got = m_tdata[21:0];
				if (report_q.size() == 0) begin
					$error("report with nothing pending: %h", m_tdata);
					fails++;
				end else begin
					exp_r = report_q.pop_front();
					if (got.small_count !== exp_r.small_count) begin
						$error("small_count exp %0d got %0d", exp_r.small_count, got.small_count);
						fails++;
					end
					if (got.medium_count !== exp_r.medium_count) begin
						$error("medium_count exp %0d got %0d", exp_r.medium_count,
							got.medium_count);
						fails++;
					end
					if (got.large_count !== exp_r.large_count) begin
						$error("large_count exp %0d got %0d", exp_r.large_count, got.large_count);
						fails++;
					end
					if (got.out_of_bins !== exp_r.out_of_bins) begin
						$error("out_of_bins exp %0d got %0d", exp_r.out_of_bins, got.out_of_bins);
						fails++;
					end
				end
				reports_seen++;
				stall = (reports_seen == 30) ? 3000 : (no_gaps ? 0 : $urandom_range(0, 12));
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic put(logic [1:0] f, int vol, int room, int cost, int w);
		word_t x;
		x.f = f;
		x.d = {w[15:0], cost[15:0], room[15:0], vol[15:0]};
		pend_words = {pend_words, x};
		if (f == vcbp_pkg::FUNC_RUN) runs_sent++;
	endtask

	task automatic settle();
		while (pend_words.size() > 0 || s_tvalid || report_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= vcbp_pkg::CFG_AW'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			vcbp_pkg::REG_SMALL: cfg_sv = v & 16'hffff;
			vcbp_pkg::REG_MEDIUM: cfg_mv = v & 16'hffff;
			default: cfg_lv = v & 16'hffff;
		endcase
	endtask

	function automatic int pick_vol();
		case ($urandom_range(0, 5))
			0: return cfg_sv;
			1: return cfg_mv;
			2: return cfg_lv;
			3: return $urandom_range(0, 65535);
			default: return $urandom_range(20, 400);
		endcase
	endfunction

	task automatic random_runs(int budget);
		int nb, ni, v, i;
		while (budget > 0) begin
			no_gaps = ($urandom_range(0, 7) == 0);
			nb = ($urandom_range(0, 19) == 0) ? 66 : $urandom_range(0, 8);
			ni = ($urandom_range(0, 29) == 0) ? 258 : $urandom_range(0, 12);
			for (i = 0; i < nb; i++) begin
				v = pick_vol();
				put(vcbp_pkg::FUNC_LOAD_BIN, v,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, v),
					($urandom_range(0, 3) == 0) ? 0 :
					(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
					$urandom_range(1, 20)),
					$urandom_range(0, 65535));
				if ($urandom_range(0, 19) == 0)
					put(2'd3, $urandom, $urandom, $urandom, $urandom);
			end
			for (i = 0; i < ni; i++)
				put(vcbp_pkg::FUNC_LOAD_ITEM, $urandom, $urandom, $urandom,
					($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
					$urandom_range(0, 150));
			put(vcbp_pkg::FUNC_RUN, $urandom, $urandom, $urandom, $urandom);
			budget -= (nb > 64 ? 64 : nb) + (ni > 256 ? 256 : ni) + 1;
		end
	endtask

	initial begin
		int p;
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		fails = 0; reports_seen = 0; runs_sent = 0; full_runs = 0; no_gaps = 0;
		cfg_sv = 0; cfg_mv = 0; cfg_lv = 0; nbins = 0; nitems = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		put(vcbp_pkg::FUNC_RUN, 0, 0, 0, 0);
		put(vcbp_pkg::FUNC_LOAD_BIN, 65535, 65535, 65535, 0);
		put(vcbp_pkg::FUNC_LOAD_BIN, 0, 0, 0, 65535);
		put(vcbp_pkg::FUNC_LOAD_BIN, 0, 65535, 7, 0);
		put(vcbp_pkg::FUNC_LOAD_ITEM, 65535, 65535, 65535, 0);
		put(vcbp_pkg::FUNC_LOAD_ITEM, 0, 0, 0, 65535);
		put(2'd3, 65535, 65535, 65535, 65535);
		put(vcbp_pkg::FUNC_RUN, 0, 0, 0, 0);
		put(vcbp_pkg::FUNC_LOAD_BIN, 10, 0, 3, 0);
		put(vcbp_pkg::FUNC_LOAD_ITEM, 0, 0, 0, 1);
		put(vcbp_pkg::FUNC_LOAD_ITEM, 0, 0, 0, 2);
		put(vcbp_pkg::FUNC_RUN, 65535, 65535, 65535, 65535);
		put(vcbp_pkg::FUNC_LOAD_BIN, 100, 100, 1, 0);
		put(vcbp_pkg::FUNC_LOAD_BIN, 100, 100, 9, 0);
		put(vcbp_pkg::FUNC_LOAD_BIN, 100, 100, 5, 0);
		put(vcbp_pkg::FUNC_LOAD_ITEM, 0, 0, 0, 60);
		put(vcbp_pkg::FUNC_LOAD_ITEM, 0, 0, 0, 60);
		put(vcbp_pkg::FUNC_RUN, 0, 0, 0, 0);
		settle();

		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin reg_write(vcbp_pkg::REG_SMALL, 100);
					reg_write(vcbp_pkg::REG_MEDIUM, 200);
					reg_write(vcbp_pkg::REG_LARGE, 400); end
				1: begin reg_write(vcbp_pkg::REG_SMALL, 65535);
					reg_write(vcbp_pkg::REG_MEDIUM, 65535);
					reg_write(vcbp_pkg::REG_LARGE, 65535); end
				2: begin reg_write(vcbp_pkg::REG_SMALL, 300);
					reg_write(vcbp_pkg::REG_MEDIUM, 50);
					reg_write(vcbp_pkg::REG_LARGE, 50); end
				default: begin reg_write(vcbp_pkg::REG_SMALL, 0);
					reg_write(vcbp_pkg::REG_MEDIUM, 120);
					reg_write(vcbp_pkg::REG_LARGE, $urandom_range(20, 400)); end
			endcase
			random_runs(320);
			settle();
		end

		$display("runs issued %0d, reports checked %0d, runs over a full store %0d",
			runs_sent, reports_seen, full_runs);
		$display("five class volume settings, long output stall after report 30");
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(12 * 6000000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
